>>> rtl/dewu_pkg.sv
// dewu_pkg: types, codes and sizes shared by the event word unpacker
// no dependencies; imported by every module of the unpacker
package dewu_pkg;

  // word position inside an event; idle also means the rest is dropped
  typedef enum logic [2:0] {
    POS_IDLE,
    POS_RATE,
    POS_ID,
    POS_LOW,
    POS_HIGH,
    POS_HEADER,
    POS_BODY
  } pos_t;

  // decoded sample rate
  typedef enum logic [1:0] {
    RATE_NONE,
    RATE_100,
    RATE_250,
    RATE_500
  } rate_t;

  // result kinds
  typedef enum logic [2:0] {
    KIND_HEADER = 3'd0,
    KIND_ENERGY = 3'd1,
    KIND_QDC    = 3'd2,
    KIND_TRACE  = 3'd3,
    KIND_ERROR  = 3'd4
  } kind_t;

  localparam logic [15:0] RATE_CODE_100 = 16'd100;
  localparam logic [15:0] RATE_CODE_250 = 16'd250;
  localparam logic [15:0] RATE_CODE_500 = 16'd500;

  // header lengths that bring energy sums and qdc sums
  localparam logic [4:0] HLEN_ENERGY = 5'd8;
  localparam logic [4:0] HLEN_QDC    = 5'd12;
  localparam logic [4:0] HLEN_BOTH   = 5'd16;
  localparam logic [2:0] ENERGY_SUMS = 3'd4;
  localparam logic [3:0] QDC_SUMS    = 4'd8;

  // time is scaled coarse count (ns, integer part) plus a signed fine offset in q.16
  localparam int SCALED_W = 48;
  localparam int FINE_W   = 24;
  localparam int TIME_W   = 64;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // one classified item waiting for the back end
  typedef struct packed {
    kind_t                     kind;
    logic                      last;
    logic [3:0]                channel_id;
    logic [3:0]                slot_id;
    logic [3:0]                crate_id;
    logic                      overflow_flag;
    logic                      finish_flag;
    logic                      cfd_fail;
    logic [15:0]               energy;
    logic [15:0]               trace_length;
    logic [SCALED_W-1:0]       scaled;
    logic signed [FINE_W-1:0]  fine;
    logic [31:0]               payload;
  } entry_t;

endpackage

>>> rtl/dewu_in_if.sv
// dewu_in_if: input channel of the unpacker, one raw event word per item
// depends on nothing
interface dewu_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] word;
  logic        start_of_event;

  modport source (output valid, output word, output start_of_event, input ready);
  modport sink (input valid, input word, input start_of_event, output ready);
endinterface

>>> rtl/dewu_out_if.sv
// dewu_out_if: result channel of the unpacker, one decoded result per item
// depends on nothing
interface dewu_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic               last;
  logic [3:0]         channel_id;
  logic [3:0]         slot_id;
  logic [3:0]         crate_id;
  logic               overflow_flag;
  logic               finish_flag;
  logic               cfd_fail;
  logic [15:0]        energy;
  logic [15:0]        trace_length;
  logic signed [63:0] timestamp;
  logic [31:0]        payload;

  modport source (
    output valid, output kind, output last, output channel_id, output slot_id,
    output crate_id, output overflow_flag, output finish_flag, output cfd_fail,
    output energy, output trace_length, output timestamp, output payload,
    input ready
  );
  modport sink (
    input valid, input kind, input last, input channel_id, input slot_id,
    input crate_id, input overflow_flag, input finish_flag, input cfd_fail,
    input energy, input trace_length, input timestamp, input payload,
    output ready
  );
endinterface

>>> rtl/dewu_front.sv
// dewu_front: takes event words, tracks the word position and classifies each word
// depends on dewu_pkg and dewu_in_if; pushes one entry per result into the queue
module dewu_front (
  input  logic              clk,
  input  logic              rst,
  dewu_in_if.sink           events,
  input  logic              q_full,
  output logic              push,
  output dewu_pkg::entry_t  entry
);
  import dewu_pkg::*;

  pos_t                     state;
  pos_t                     state_next;
  rate_t                    rate;
  logic [31:0]              id_word;
  logic [31:0]              stamp_low;
  logic [SCALED_W-1:0]      scaled;
  logic signed [FINE_W-1:0] fine;
  logic                     cfd_fail;
  logic [2:0]               energy_left;
  logic [3:0]               qdc_left;
  logic [14:0]              trace_left;

  logic                     accept;
  logic [31:0]              w;
  logic                     start;

  // header decode
  logic [4:0]               hlen;
  logic [12:0]              clen;
  logic [15:0]              tlen;
  logic [15:0]              expect_len;
  logic                     bad;
  logic                     has_body;
  logic [2:0]               energy_init;
  logic [3:0]               qdc_init;
  logic [14:0]              trace_init;
  logic                     header_fin;

  // body decode
  kind_t                    body_kind;
  logic                     body_empty;
  logic [2:0]               energy_dec;
  logic [3:0]               qdc_dec;
  logic [14:0]              trace_dec;
  logic                     body_last;

  // time terms from words 3 and 4
  logic [47:0]              coarse;
  logic [SCALED_W-1:0]      scaled_calc;
  logic signed [FINE_W-1:0] fine_calc;
  logic [FINE_W-1:0]        cfd100;
  logic [FINE_W-1:0]        cfd250;
  logic [FINE_W-1:0]        cfd500;
  logic [FINE_W-1:0]        src250;
  logic [FINE_W-1:0]        src500;

  assign events.ready = !q_full;
  assign accept       = events.valid && events.ready;
  assign w            = events.word;
  assign start        = events.start_of_event;

  // length check on the energy word
  assign hlen       = id_word[16:12];
  assign clen       = id_word[29:17];
  assign tlen       = w[31:16];
  assign expect_len = 16'(hlen) + {1'b0, tlen[15:1]};
  assign bad        = (13'(hlen) != clen) && (16'(clen) != expect_len);
  assign has_body   = !bad && (13'(hlen) != clen);
  always_comb begin
    energy_init = 3'd0;
    qdc_init    = 4'd0;
    trace_init  = 15'd0;
    if (has_body) begin
      if (hlen == HLEN_ENERGY || hlen == HLEN_BOTH) begin
        energy_init = ENERGY_SUMS;
      end
      if (hlen == HLEN_QDC || hlen == HLEN_BOTH) begin
        qdc_init = QDC_SUMS;
      end
      trace_init = tlen[15:1];
    end
  end
  assign header_fin = bad || (energy_init == 3'd0 && qdc_init == 4'd0 && trace_init == 15'd0);

  // body word: energy sums first, then qdc sums, then trace pairs
  always_comb begin
    body_kind  = KIND_TRACE;
    body_empty = 1'b0;
    energy_dec = energy_left;
    qdc_dec    = qdc_left;
    trace_dec  = trace_left;
    if (energy_left != 3'd0) begin
      body_kind  = KIND_ENERGY;
      energy_dec = energy_left - 3'd1;
    end else if (qdc_left != 4'd0) begin
      body_kind = KIND_QDC;
      qdc_dec   = qdc_left - 4'd1;
    end else if (trace_left != 15'd0) begin
      body_kind = KIND_TRACE;
      trace_dec = trace_left - 15'd1;
    end else begin
      body_empty = 1'b1;
    end
  end
  assign body_last = (energy_dec == 3'd0) && (qdc_dec == 4'd0) && (trace_dec == 15'd0);

  // time terms: coarse times 10 ns (8 ns at rate 250), cfd fraction, source offset
  assign coarse = {w[15:0], stamp_low};
  assign cfd100 = (FINE_W'(w[30:16]) << 4) + (FINE_W'(w[30:16]) << 2);
  assign cfd250 = FINE_W'(w[29:16]) << 4;
  assign cfd500 = FINE_W'(w[28:16]) << 4;
  assign src250 = FINE_W'(w[30]) << 18;
  assign src500 = FINE_W'(w[31:29]) << 17;
  always_comb begin
    case (rate)
      RATE_100: begin
        scaled_calc = (coarse << 3) + (coarse << 1);
        fine_calc   = signed'(cfd100);
      end
      RATE_250: begin
        scaled_calc = coarse << 3;
        fine_calc   = signed'(cfd250 - src250);
      end
      RATE_500: begin
        scaled_calc = (coarse << 3) + (coarse << 1);
        fine_calc   = signed'(cfd500 + src500 - (FINE_W'(1) << 17));
      end
      default: begin
        scaled_calc = '0;
        fine_calc   = '0;
      end
    endcase
  end

  // next word position
  always_comb begin
    state_next = state;
    if (accept) begin
      if (start) begin
        state_next = POS_RATE;
      end else begin
        unique case (state)
          POS_IDLE:   state_next = POS_IDLE;
          POS_RATE:   state_next = POS_ID;
          POS_ID:     state_next = POS_LOW;
          POS_LOW:    state_next = POS_HIGH;
          POS_HIGH:   state_next = POS_HEADER;
          POS_HEADER: state_next = header_fin ? POS_IDLE : POS_BODY;
          POS_BODY:   state_next = (body_empty || body_last) ? POS_IDLE : POS_BODY;
          default:    state_next = POS_IDLE;
        endcase
      end
    end
  end

  // queue entry for the current word
  always_comb begin
    push                = 1'b0;
    entry               = '0;
    entry.channel_id    = id_word[3:0];
    entry.slot_id       = id_word[7:4];
    entry.crate_id      = id_word[11:8];
    entry.overflow_flag = id_word[30];
    entry.finish_flag   = id_word[31];
    unique case (state)
      POS_HEADER: begin
        push               = accept && !start;
        entry.kind         = bad ? KIND_ERROR : KIND_HEADER;
        entry.last         = header_fin;
        entry.cfd_fail     = cfd_fail;
        entry.energy       = w[15:0];
        entry.trace_length = tlen;
        entry.scaled       = scaled;
        entry.fine         = fine;
      end
      POS_BODY: begin
        push          = accept && !start && !body_empty;
        entry.kind    = body_kind;
        entry.last    = body_last;
        entry.payload = w;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= POS_IDLE;
      energy_left <= 3'd0;
      qdc_left    <= 4'd0;
      trace_left  <= 15'd0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (start) begin
          energy_left <= 3'd0;
          qdc_left    <= 4'd0;
          trace_left  <= 15'd0;
        end else if (state == POS_HEADER) begin
          energy_left <= energy_init;
          qdc_left    <= qdc_init;
          trace_left  <= trace_init;
        end else if (state == POS_BODY) begin
          energy_left <= energy_dec;
          qdc_left    <= qdc_dec;
          trace_left  <= trace_dec;
        end
      end
    end
  end

  // header words captured as they pass
  always_ff @(posedge clk) begin
    if (rst) begin
      rate <= RATE_NONE;
    end else if (accept && !start && state == POS_RATE) begin
      if (w[15:0] == RATE_CODE_100) begin
        rate <= RATE_100;
      end else if (w[15:0] == RATE_CODE_250) begin
        rate <= RATE_250;
      end else if (w[15:0] == RATE_CODE_500) begin
        rate <= RATE_500;
      end else begin
        rate <= RATE_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !start) begin
      if (state == POS_ID) begin
        id_word <= w;
      end
      if (state == POS_LOW) begin
        stamp_low <= w;
      end
      if (state == POS_HIGH) begin
        scaled   <= scaled_calc;
        fine     <= fine_calc;
        cfd_fail <= (rate == RATE_100 || rate == RATE_250) ? w[31] : 1'b0;
      end
    end
  end

endmodule

>>> rtl/dewu_queue.sv
// dewu_queue: short first-in first-out queue of classified entries
// depends on dewu_pkg; sits between the front and the back of the unpacker
module dewu_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  dewu_pkg::entry_t  entry,
  output logic              full,
  output logic              head_valid,
  output dewu_pkg::entry_t  head,
  input  logic              pop
);
  import dewu_pkg::*;

  entry_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push;
  logic                do_pop;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/dewu_back.sv
// dewu_back: finishes the event time and holds the result in the output register
// depends on dewu_pkg and dewu_out_if; drains the queue filled by the front
module dewu_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  dewu_pkg::entry_t  head,
  output logic              pop,
  dewu_out_if.source        results
);
  import dewu_pkg::*;

  logic signed [TIME_W-1:0] time_sum;

  // time in q.16: scaled ns count in the integer part plus the signed fraction offset
  assign time_sum = signed'({head.scaled[TIME_W-17:0], 16'd0}
                            + {{(TIME_W - FINE_W){head.fine[FINE_W-1]}}, head.fine});

  assign pop = head_valid && (!results.valid || results.ready);

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (pop) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (pop) begin
      results.kind          <= head.kind;
      results.last          <= head.last;
      results.channel_id    <= head.channel_id;
      results.slot_id       <= head.slot_id;
      results.crate_id      <= head.crate_id;
      results.overflow_flag <= head.overflow_flag;
      results.finish_flag   <= head.finish_flag;
      results.cfd_fail      <= head.cfd_fail;
      results.energy        <= head.energy;
      results.trace_length  <= head.trace_length;
      results.timestamp     <= time_sum;
      results.payload       <= head.payload;
    end
  end

endmodule

>>> rtl/digitizer_event_word_unpacker.sv
// digitizer_event_word_unpacker: top level of the digitizer event word unpacker
// depends on dewu_pkg, dewu_in_if, dewu_out_if, dewu_front, dewu_queue, dewu_back
//
// Usage:
//   events carries one 32-bit event word per item; start_of_event marks word 0.
//   Words 1 to 4 (rate, ids and lengths, timestamp low, timestamp high and cfd)
//   give no result. Word 5 gives a header result, or a length error result that
//   ends the event. Energy sums, qdc sums and trace pairs follow, one result per
//   word, and last marks the final result. Words outside an event are ignored.
//   Throughput is one word per cycle while the queue is not full. A result's word
//   is written into the four-entry queue when it is accepted; the result then
//   moves from the queue into the output register, where the event time is added
//   up.
//   When results stalls, the queue keeps taking words until it holds four
//   entries; events.ready then stays low until the output register hands its
//   result over and the queue pops.
//   Words that give no result never wait on the queue unless it is full.
//   Reset (rst, synchronous) empties the queue and the output register and
//   makes the block ignore words until the next start_of_event.
module digitizer_event_word_unpacker (
  input  logic      clk,
  input  logic      rst,
  dewu_in_if.sink   events,
  dewu_out_if.source results
);
  import dewu_pkg::*;

  logic   push;
  entry_t entry;
  logic   q_full;
  logic   head_valid;
  entry_t head;
  logic   pop;

  // word tracking and classification
  dewu_front u_front (
    .clk    (clk),
    .rst    (rst),
    .events (events),
    .q_full (q_full),
    .push   (push),
    .entry  (entry)
  );

  // decoupling queue
  dewu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .entry      (entry),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  // time assembly and output register
  dewu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .results    (results)
  );

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking testbench for digitizer_event_word_unpacker
// feeds whole, cut short, bad length and noisy events, predicts every decoded result
// depends on dewu_pkg, dewu_in_if, dewu_out_if and the unpacker rtl
module tb_top;
  import dewu_pkg::*;

  localparam int RANDOM_WORDS  = 550;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 20;
  localparam int LONG_HOLD     = 200;
  localparam int NO_CUT        = 1 << 30;
  // one ns in q.16, and the fine step per rate
  localparam logic [63:0] Q16_ONE  = 64'd65536;
  localparam logic [63:0] FINE_100 = 64'd20;
  localparam logic [63:0] FINE_STEP = 64'd16;

  typedef struct packed {
    kind_t        kind;
    logic         last;
    logic [3:0]   channel_id;
    logic [3:0]   slot_id;
    logic [3:0]   crate_id;
    logic         overflow_flag;
    logic         finish_flag;
    logic         cfd_fail;
    logic [15:0]  energy;
    logic [15:0]  trace_length;
    logic [63:0]  timestamp;
    logic [31:0]  payload;
  } decoded_t;

  typedef struct {
    logic [31:0] word;
    logic        sof;
    bit          drain;
  } word_item_t;

  logic clk;
  logic rst;

  dewu_in_if  evt_in ();
  dewu_out_if dec_out ();

  digitizer_event_word_unpacker DUT (
    .clk     (clk),
    .rst     (rst),
    .events  (evt_in),
    .results (dec_out)
  );

  // event decoder state, as the block holds it
  pos_t        evt_pos = POS_IDLE;
  logic [15:0] evt_rate = '0;
  logic [31:0] evt_ids = '0;
  logic [31:0] evt_stamp_low = '0;
  logic [31:0] evt_stamp_high = '0;
  logic [2:0]  energy_left = '0;
  logic [3:0]  qdc_left = '0;
  logic [14:0] pairs_left = '0;
  bit          evt_dropped = 1'b1;

  decoded_t   decoded_queue[$];
  word_item_t word_queue[$];
  word_item_t head;

  int mismatches = 0;
  int results_seen = 0;
  int cycles = 0;
  int send_gap = 0;
  int rcv_hold = 0;
  bit send_calm = 1'b0;
  bit rcv_calm = 1'b0;

  // clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // event time in ns, q48.16, wrapping mod 2^64
  function automatic logic [63:0] event_time_q16();
    logic [63:0] coarse;
    coarse = {16'd0, evt_stamp_high[15:0], evt_stamp_low};
    case (evt_rate)
      RATE_CODE_100: begin
        return coarse * 64'd10 * Q16_ONE + {49'd0, evt_stamp_high[30:16]} * FINE_100;
      end
      RATE_CODE_250: begin
        return coarse * 64'd8 * Q16_ONE + {50'd0, evt_stamp_high[29:16]} * FINE_STEP
               - {63'd0, evt_stamp_high[30]} * 64'd4 * Q16_ONE;
      end
      RATE_CODE_500: begin
        return coarse * 64'd10 * Q16_ONE + {51'd0, evt_stamp_high[28:16]} * FINE_STEP
               + {61'd0, evt_stamp_high[31:29]} * 64'd2 * Q16_ONE - 64'd2 * Q16_ONE;
      end
      default: begin
        return 64'd0;
      end
    endcase
  endfunction

  // ids and flags repeated on every result of the event
  function automatic decoded_t id_fields();
    decoded_t r;
    r = '0;
    r.channel_id = evt_ids[3:0];
    r.slot_id = evt_ids[7:4];
    r.crate_id = evt_ids[11:8];
    r.overflow_flag = evt_ids[30];
    r.finish_flag = evt_ids[31];
    return r;
  endfunction

  // advance the decoder by one accepted word, queue the result it gives
  function automatic void unpack_word(logic [31:0] w, logic sof);
    decoded_t r;
    int unsigned hl;
    int unsigned cl;
    int unsigned tl;
    bit bad;
    if (sof) begin
      evt_pos = POS_RATE;
      evt_dropped = 1'b0;
      energy_left = '0;
      qdc_left = '0;
      pairs_left = '0;
      return;
    end
    if (evt_dropped) begin
      return;
    end
    case (evt_pos)
      POS_RATE: begin
        evt_rate = w[15:0];
        evt_pos = POS_ID;
      end
      POS_ID: begin
        evt_ids = w;
        evt_pos = POS_LOW;
      end
      POS_LOW: begin
        evt_stamp_low = w;
        evt_pos = POS_HIGH;
      end
      POS_HIGH: begin
        evt_stamp_high = w;
        evt_pos = POS_HEADER;
      end
      POS_HEADER: begin
        hl = 32'(evt_ids[16:12]);
        cl = 32'(evt_ids[29:17]);
        tl = 32'(w[31:16]);
        bad = (hl != cl) && (cl != hl + tl / 2);
        energy_left = '0;
        qdc_left = '0;
        pairs_left = '0;
        if (!bad && hl != cl) begin
          if (hl == HLEN_ENERGY || hl == HLEN_BOTH) begin
            energy_left = ENERGY_SUMS;
          end
          if (hl == HLEN_QDC || hl == HLEN_BOTH) begin
            qdc_left = QDC_SUMS;
          end
          pairs_left = w[31:17];
        end
        r = id_fields();
        if (bad) begin
          r.kind = KIND_ERROR;
        end else begin
          r.kind = KIND_HEADER;
        end
        r.last = bad || (energy_left == 0 && qdc_left == 0 && pairs_left == 0);
        if (evt_rate == RATE_CODE_100 || evt_rate == RATE_CODE_250) begin
          r.cfd_fail = evt_stamp_high[31];
        end
        r.energy = w[15:0];
        r.trace_length = w[31:16];
        r.timestamp = event_time_q16();
        decoded_queue = {decoded_queue, r};
        if (r.last) begin
          evt_dropped = 1'b1;
          evt_pos = POS_IDLE;
        end else begin
          evt_pos = POS_BODY;
        end
      end
      POS_BODY: begin
        r = id_fields();
        if (energy_left != 0) begin
          r.kind = KIND_ENERGY;
          energy_left = energy_left - 3'd1;
        end else if (qdc_left != 0) begin
          r.kind = KIND_QDC;
          qdc_left = qdc_left - 4'd1;
        end else if (pairs_left != 0) begin
          r.kind = KIND_TRACE;
          pairs_left = pairs_left - 15'd1;
        end else begin
          evt_dropped = 1'b1;
          evt_pos = POS_IDLE;
          return;
        end
        r.last = (energy_left == 0 && qdc_left == 0 && pairs_left == 0);
        r.payload = w;
        decoded_queue = {decoded_queue, r};
        if (r.last) begin
          evt_dropped = 1'b1;
          evt_pos = POS_IDLE;
        end
      end
      default: begin
        evt_dropped = 1'b1;
        evt_pos = POS_IDLE;
      end
    endcase
  endfunction

  function automatic bit field_ok(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // compare one accepted result against the oldest prediction
  function automatic void check_result();
    decoded_t want;
    bit ok;
    if (decoded_queue.size() == 0) begin
      $display("%0t: result expected none got kind %0d payload %0h", $time,
               dec_out.kind, dec_out.payload);
      mismatches++;
      return;
    end
    want = decoded_queue.pop_front();
    ok = field_ok("kind", want.kind, dec_out.kind);
    ok = ok & field_ok("last", want.last, dec_out.last);
    ok = ok & field_ok("channel_id", want.channel_id, dec_out.channel_id);
    ok = ok & field_ok("slot_id", want.slot_id, dec_out.slot_id);
    ok = ok & field_ok("crate_id", want.crate_id, dec_out.crate_id);
    ok = ok & field_ok("overflow_flag", want.overflow_flag, dec_out.overflow_flag);
    ok = ok & field_ok("finish_flag", want.finish_flag, dec_out.finish_flag);
    ok = ok & field_ok("cfd_fail", want.cfd_fail, dec_out.cfd_fail);
    ok = ok & field_ok("energy", want.energy, dec_out.energy);
    ok = ok & field_ok("trace_length", want.trace_length, dec_out.trace_length);
    ok = ok & field_ok("timestamp", want.timestamp, dec_out.timestamp);
    ok = ok & field_ok("payload", want.payload, dec_out.payload);
    if (!ok) begin
      mismatches++;
    end
  endfunction

  // mostly short gaps, a few long ones, none in a calm stretch
  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 25);
  endfunction

  function automatic void push_word(logic [31:0] w, logic sof, bit drain);
    word_item_t it;
    it.word = w;
    it.sof = sof;
    it.drain = drain;
    word_queue = {word_queue, it};
  endfunction

  // header lengths bring sums; trace pairs follow
  function automatic int body_words(logic [4:0] hl, logic [12:0] cl, logic [15:0] tl);
    int n;
    n = 0;
    if (hl == cl) begin
      return 0;
    end
    if (hl == HLEN_ENERGY || hl == HLEN_BOTH) begin
      n += ENERGY_SUMS;
    end
    if (hl == HLEN_QDC || hl == HLEN_BOTH) begin
      n += QDC_SUMS;
    end
    return n + tl / 2;
  endfunction

  // queue one event, at most cut words of it; returns the words queued
  function automatic int add_event(logic [15:0] rate, logic [4:0] hl, logic [12:0] cl,
                                   logic [15:0] tl, logic [31:0] ids, logic [31:0] low,
                                   logic [31:0] high, int body, int cut, bit drain);
    int total;
    int k;
    logic [31:0] w;
    total = (cut < 6 + body) ? cut : 6 + body;
    for (k = 0; k < total; k++) begin
      case (k)
        0: w = $urandom;
        1: w = {16'($urandom), rate};
        2: w = {ids[31:30], cl, hl, ids[11:0]};
        3: w = low;
        4: w = high;
        5: w = {tl, 16'($urandom)};
        default: w = $urandom;
      endcase
      push_word(w, k == 0, drain && k == 0);
    end
    return total;
  endfunction

  function automatic logic [15:0] pick_rate();
    case ($urandom_range(0, 9))
      0, 1, 2: return RATE_CODE_100;
      3, 4, 5: return RATE_CODE_250;
      6, 7, 8: return RATE_CODE_500;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [4:0] pick_hlen();
    case ($urandom_range(0, 4))
      0: return HLEN_ENERGY;
      1: return HLEN_QDC;
      2: return HLEN_BOTH;
      default: return 5'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_tlen();
    if ($urandom_range(0, 9) == 0) begin
      return 16'($urandom_range(0, 300));
    end
    return 16'($urandom_range(0, 40));
  endfunction

  // word sender: offers the queued words, predicts on each accept
  always @(posedge clk) begin
    if (rst) begin
      evt_in.valid <= 1'b0;
      evt_in.word <= '0;
      evt_in.start_of_event <= 1'b0;
      send_gap <= 0;
    end else begin
      if (evt_in.valid && evt_in.ready) begin
        unpack_word(evt_in.word, evt_in.start_of_event);
      end
      if (!evt_in.valid || evt_in.ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          evt_in.valid <= 1'b0;
        end else if (word_queue.size() != 0 &&
                     !(word_queue[0].drain && decoded_queue.size() != 0)) begin
          head = word_queue.pop_front();
          evt_in.valid <= 1'b1;
          evt_in.word <= head.word;
          evt_in.start_of_event <= head.sof;
          send_gap <= pick_gap(send_calm);
        end else begin
          evt_in.valid <= 1'b0;
        end
      end
      if ($urandom_range(0, 59) == 0) begin
        send_calm <= !send_calm;
      end
    end
  end

  // result receiver: checks each accepted item, stalls at random
  always @(posedge clk) begin
    if (rst) begin
      dec_out.ready <= 1'b0;
      rcv_hold <= 0;
    end else begin
      if (dec_out.valid && dec_out.ready) begin
        check_result();
        results_seen++;
      end
      if (rcv_hold != 0) begin
        rcv_hold <= rcv_hold - 1;
        dec_out.ready <= 1'b0;
      end else if (dec_out.valid && dec_out.ready &&
                   (results_seen == 100 || results_seen == 300)) begin
        // long back-pressure so the queue fills and the input stalls
        rcv_hold <= LONG_HOLD;
        dec_out.ready <= 1'b0;
      end else if (!rcv_calm && $urandom_range(0, 3) == 0) begin
        rcv_hold <= pick_gap(1'b0);
        dec_out.ready <= 1'b0;
      end else begin
        dec_out.ready <= 1'b1;
      end
      if ($urandom_range(0, 49) == 0) begin
        rcv_calm <= !rcv_calm;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    int words_planned;
    int sel;
    int body;
    int n;
    bit drain_now;
    bit drained;
    logic [15:0] rate;
    logic [4:0] hl;
    logic [12:0] cl;
    logic [15:0] tl;

    rst = 1'b1;

    // stray word before any start is ignored
    push_word('1, 1'b0, 1'b0);
    // rate 100, header only, every flag set, coarse time wraps
    void'(add_event(RATE_CODE_100, 5'd8, 13'd8, 16'hFFFF, '1, '1, '1, 0, NO_CUT, 1'b0));
    // rate 500, energy sums then one trace pair, top source and cfd
    void'(add_event(RATE_CODE_500, HLEN_ENERGY, 13'd9, 16'd2, '0, '1, '1, 5, NO_CUT,
                    1'b0));
    // rate 250, length mismatch at maximum channel length, negative time
    void'(add_event(RATE_CODE_250, HLEN_QDC, 13'h1FFF, 16'd0, $urandom, '0,
                    32'h4000_0000, 1, NO_CUT, 1'b0));
    // rate 500 at zero coarse time, qdc sums, new start in mid-event
    void'(add_event(RATE_CODE_500, HLEN_QDC, 13'd14, 16'd4, $urandom, '0, '0, 10, 7,
                    1'b0));
    // unknown rate gives zero time and no cfd failure
    void'(add_event(16'hFFFF, HLEN_BOTH, 13'd16, 16'd0, $urandom, '1, '1, 0, NO_CUT,
                    1'b0));

    // random events, mostly well formed
    words_planned = 0;
    drained = 1'b1;
    while (words_planned < RANDOM_WORDS) begin
      drain_now = drained;
      drained = 1'b0;
      if (words_planned >= RANDOM_WORDS / 2 && words_planned < RANDOM_WORDS / 2 + 40) begin
        drain_now = 1'b1;
      end
      rate = pick_rate();
      hl = pick_hlen();
      tl = pick_tlen();
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        cl = 13'(hl + tl / 2);
        body = body_words(hl, cl, tl);
        if ($urandom_range(0, 7) == 0) begin
          body += $urandom_range(1, 3);
        end
        words_planned += add_event(rate, hl, cl, tl, $urandom, $urandom, $urandom, body,
                                   NO_CUT, drain_now);
      end else if (sel < 72) begin
        // header only, any trace length
        tl = 16'($urandom);
        words_planned += add_event(rate, hl, 13'(hl), tl, $urandom, $urandom, $urandom, 0,
                                   NO_CUT, drain_now);
      end else if (sel < 84) begin
        // bad length, trailing words get dropped
        tl = 16'($urandom);
        do begin
          cl = 13'($urandom);
        end while (cl == hl || int'(cl) == int'(hl) + int'(tl) / 2);
        words_planned += add_event(rate, hl, cl, tl, $urandom, $urandom, $urandom,
                                   $urandom_range(0, 3), NO_CUT, drain_now);
      end else if (sel < 94) begin
        // cut short, the next start abandons it
        cl = 13'(hl + tl / 2);
        body = body_words(hl, cl, tl);
        words_planned += add_event(rate, hl, cl, tl, $urandom, $urandom, $urandom, body,
                                   $urandom_range(1, 5 + body), drain_now);
      end else begin
        // noise, now and then with a start mark
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++) begin
          push_word($urandom, $urandom_range(0, 7) == 0, drain_now && k == 0);
        end
        words_planned += n;
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (word_queue.size() != 0 || evt_in.valid) begin
      @(posedge clk);
    end
    while (decoded_queue.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/dewu_pkg.sv
rtl/dewu_in_if.sv
rtl/dewu_out_if.sv
rtl/dewu_front.sv
rtl/dewu_queue.sv
rtl/dewu_back.sv
rtl/digitizer_event_word_unpacker.sv
dv/tb_top.sv
